@@ sv/msss_pkg.sv @@
// Shared constants for the multi-stack shared store.
`timescale 1ns / 1ps
`default_nettype none

package msss_pkg;

    localparam int NUM_STACKS_DEF = 4;
    localparam int DEPTH_DEF      = 16;

    localparam int DATA_W = 32;
    localparam int ID_W   = 2;
    localparam int ST_W   = 2;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [ST_W-1:0] ST_BADID = 2'd3;

endpackage

`default_nettype wire

@@ sv/msss_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module msss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/multi_stack_shared_store.sv @@
// Top level of the multi-stack shared store.
// NUM_STACKS LIFO stacks share DEPTH slots held in one slot RAM, whose words carry the
// data and a link to the slot below; freed slots are chained through the same links,
// slots never used are handed out downward from the top, and the top pointers of the
// stacks sit in a second RAM. Each beat is one push or pop and yields exactly one result
// beat. For a push, a bad stack id or a pop on an empty stack, the result enters the
// output register from the state that takes the registered top-pointer read; for a
// successful pop it enters after a further read of the slot RAM. Either waits while the
// output register still holds an untaken result. The next beat is taken in the cycle
// after the result is loaded. One item is in work at a time; a new beat is taken while the
// previous result waits at the output. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module multi_stack_shared_store import msss_pkg::*; #(
    parameter int NUM_STACKS = NUM_STACKS_DEF,
    parameter int DEPTH      = DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic                     i_mode,
    input  wire logic        [ID_W-1:0]   i_stack_id,
    input  wire logic signed [DATA_W-1:0] i_data_in,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic             [ST_W-1:0]   o_status,
    output logic signed      [DATA_W-1:0] o_data_out
);

    localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int WW = DATA_W + LW;
    localparam logic [LW-1:0] NULL_LINK = LW'(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TOP  = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;

    logic [1:0]              r_state, n_state;
    logic                    r_mode, n_mode;
    logic [ID_W-1:0]         r_sid, n_sid;
    logic [DATA_W-1:0]       r_data, n_data;
    logic [LW-1:0]           r_slot, n_slot;
    logic [LW-1:0]           r_free_head, n_free_head;
    logic [LW-1:0]           r_low, n_low;
    logic [NUM_STACKS-1:0]   r_tvalid, n_tvalid;
    logic                    r_out_valid, n_out_valid;
    logic [ST_W-1:0]         r_status, n_status;
    logic [DATA_W-1:0]       r_data_out, n_data_out;

    logic                    w_top_we, w_top_re;
    logic [SW-1:0]           w_top_raddr;
    logic [LW-1:0]           w_top_wdata, w_top_rdata;
    logic                    w_slot_we, w_slot_re;
    logic [AW-1:0]           w_slot_waddr, w_slot_raddr;
    logic [WW-1:0]           w_slot_wdata, w_slot_rdata;

    logic [SW-1:0]           w_sidx;
    logic                    w_bad;
    logic                    w_out_free;
    logic [LW-1:0]           w_top;
    logic [LW-1:0]           w_next_free;

    assign w_sidx     = SW'(r_sid);
    assign w_bad      = int'(r_sid) >= NUM_STACKS;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_top      = r_tvalid[w_sidx] ? w_top_rdata : NULL_LINK;

    always_comb begin
        if (r_free_head < r_low) begin
            w_next_free = (r_free_head == '0) ? NULL_LINK : r_free_head - LW'(1);
        end else begin
            w_next_free = w_slot_rdata[LW-1:0];
        end
    end

    msss_ram #(
        .WIDTH(LW),
        .DEPTH(NUM_STACKS)
    ) u_top_ram (
        .i_clk  (i_clk),
        .i_we   (w_top_we),
        .i_waddr(w_sidx),
        .i_wdata(w_top_wdata),
        .i_re   (w_top_re),
        .i_raddr(w_top_raddr),
        .o_rdata(w_top_rdata)
    );

    msss_ram #(
        .WIDTH(WW),
        .DEPTH(DEPTH)
    ) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (w_slot_we),
        .i_waddr(w_slot_waddr),
        .i_wdata(w_slot_wdata),
        .i_re   (w_slot_re),
        .i_raddr(w_slot_raddr),
        .o_rdata(w_slot_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_sid       = r_sid;
        n_data      = r_data;
        n_slot      = r_slot;
        n_free_head = r_free_head;
        n_low       = r_low;
        n_tvalid    = r_tvalid;
        n_status    = r_status;
        n_data_out  = r_data_out;
        n_out_valid = r_out_valid && !i_ready;

        w_top_we     = 1'b0;
        w_top_re     = 1'b0;
        w_top_raddr  = SW'(i_stack_id);
        w_top_wdata  = r_free_head;
        w_slot_we    = 1'b0;
        w_slot_re    = 1'b0;
        w_slot_raddr = r_free_head[AW-1:0];
        w_slot_waddr = r_free_head[AW-1:0];
        w_slot_wdata = {r_data, w_top};

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_mode    = i_mode;
                    n_sid     = i_stack_id;
                    n_data    = i_data_in;
                    w_top_re  = 1'b1;
                    w_slot_re = 1'b1;
                    n_state   = S_TOP;
                end
            end
            S_TOP: begin
                if (w_bad) begin
                    if (w_out_free) begin
                        n_status    = ST_BADID;
                        n_data_out  = '0;
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else if (r_mode == MODE_POP) begin
                    if (w_top == NULL_LINK) begin
                        if (w_out_free) begin
                            n_status    = ST_EMPTY;
                            n_data_out  = '0;
                            n_out_valid = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end else begin
                        w_slot_re    = 1'b1;
                        w_slot_raddr = w_top[AW-1:0];
                        n_slot       = w_top;
                        n_state      = S_POP;
                    end
                end else if (r_free_head == NULL_LINK) begin
                    if (w_out_free) begin
                        n_status    = ST_FULL;
                        n_data_out  = '0;
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else if (w_out_free) begin
                    w_slot_we          = 1'b1;
                    w_top_we           = 1'b1;
                    n_tvalid[w_sidx]   = 1'b1;
                    n_free_head        = w_next_free;
                    n_low              = (r_free_head < r_low) ? r_free_head : r_low;
                    n_status           = ST_OK;
                    n_data_out         = '0;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_POP: begin
                if (w_out_free) begin
                    w_top_we     = 1'b1;
                    w_top_wdata  = w_slot_rdata[LW-1:0];
                    w_slot_we    = 1'b1;
                    w_slot_waddr = r_slot[AW-1:0];
                    w_slot_wdata = {w_slot_rdata[WW-1:LW], r_free_head};
                    n_free_head  = r_slot;
                    n_status     = ST_OK;
                    n_data_out   = w_slot_rdata[WW-1:LW];
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= LW'(DEPTH - 1);
            r_low       <= NULL_LINK;
            r_tvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_low       <= n_low;
            r_tvalid    <= n_tvalid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_sid      <= n_sid;
        r_data     <= n_data;
        r_slot     <= n_slot;
        r_status   <= n_status;
        r_data_out <= n_data_out;
    end

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_status   = r_status;
    assign o_data_out = r_data_out;

endmodule

`default_nettype wire

@@ tb/sv/tb_multi_stack_shared_store.sv @@
// Self-checking testbench for the multi-stack shared store with a built-in stack predictor.
`timescale 1ns / 1ps

module tb_multi_stack_shared_store;
    import msss_pkg::*;

    localparam int NUM_STACKS = NUM_STACKS_DEF;
    localparam int DEPTH      = DEPTH_DEF;
    localparam int SLOT_W     = $clog2(DEPTH) + 1;
    localparam int RANDOM_OPS = 450;

    typedef struct packed {
        logic              mode;
        logic [ID_W-1:0]   sid;
        logic [DATA_W-1:0] data;
        logic              typed;
        logic [ST_W-1:0]   st;
        logic [DATA_W-1:0] dout;
    } stim_row_t;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [DATA_W-1:0] data;
    } op_result_t;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic                     i_mode;
    logic        [ID_W-1:0]   i_stack_id;
    logic signed [DATA_W-1:0] i_data_in;
    logic                     o_valid;
    logic                     i_ready;
    logic        [ST_W-1:0]   o_status;
    logic signed [DATA_W-1:0] o_data_out;

    logic [DATA_W-1:0] slot_value [DEPTH];
    logic [SLOT_W-1:0] slot_below [DEPTH];
    logic [SLOT_W-1:0] top_slot   [NUM_STACKS];
    logic [SLOT_W-1:0] free_pool  [DEPTH];
    int                free_left;

    op_result_t pending_results [$];
    op_result_t head_result;
    stim_row_t  directed_ops [16];
    int         errors;
    int         results_seen;
    int         burst_left;

    multi_stack_shared_store DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_mode     (i_mode),
        .i_stack_id (i_stack_id),
        .i_data_in  (i_data_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_status   (o_status),
        .o_data_out (o_data_out)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic clear_stacks();
        for (int k = 0; k < DEPTH; k++) begin
            slot_value[k] = '0;
            slot_below[k] = SLOT_W'(DEPTH);
            free_pool[k]  = SLOT_W'(k);
        end
        for (int k = 0; k < NUM_STACKS; k++) begin
            top_slot[k] = SLOT_W'(DEPTH);
        end
        free_left = DEPTH;
    endtask

    task automatic apply_stack_op(input logic op, input logic [ID_W-1:0] sid,
                                  input logic [DATA_W-1:0] data, output op_result_t res);
        logic [SLOT_W-1:0] slot;
        res.status = ST_OK;
        res.data   = '0;
        if (int'(sid) >= NUM_STACKS) begin
            res.status = ST_BADID;
        end else if (op == MODE_PUSH) begin
            if (free_left == 0) begin
                res.status = ST_FULL;
            end else begin
                free_left--;
                slot             = free_pool[free_left];
                slot_value[slot] = data;
                slot_below[slot] = top_slot[sid];
                top_slot[sid]    = slot;
            end
        end else begin
            slot = top_slot[sid];
            if (int'(slot) >= DEPTH) begin
                res.status = ST_EMPTY;
            end else begin
                res.data      = slot_value[slot];
                top_slot[sid] = slot_below[slot];
                if (free_left < DEPTH) begin
                    free_pool[free_left] = slot;
                    free_left++;
                end
            end
        end
    endtask

    task automatic send_op(input stim_row_t row);
        op_result_t res;
        int gap;
        i_valid    <= 1'b1;
        i_mode     <= row.mode;
        i_stack_id <= row.sid;
        i_data_in  <= row.data;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        apply_stack_op(row.mode, row.sid, row.data, res);
        if (row.typed) begin
            res.status = row.st;
            res.data   = row.dout;
        end
        pending_results.push_back(res);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    function automatic logic [DATA_W-1:0] pick_data();
        case ($urandom_range(0, 11))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("Result beat with nothing expected: status %0d data_out %h",
                       o_status, o_data_out);
                errors++;
            end else begin
                head_result = pending_results.pop_front();
                if (o_status !== head_result.status) begin
                    $error("status: expected %0d, actual %0d", head_result.status, o_status);
                    errors++;
                end
                if (o_data_out !== head_result.data) begin
                    $error("data_out: expected %h, actual %h", head_result.data, o_data_out);
                    errors++;
                end
            end
        end
    end

    initial begin : receiver
        int pattern;
        int span;
        bit held;
        held = 1'b0;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && results_seen >= 150) begin
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (80) @(posedge i_clk);
            end else begin
                pattern = $urandom_range(0, 2);
                span    = $urandom_range(8, 40);
                for (int k = 0; k < span; k++) begin
                    case (pattern)
                        0: i_ready <= 1'b1;
                        1: i_ready <= ($urandom_range(0, 1) == 1);
                        default: i_ready <= (k % 3 == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin : sender
        stim_row_t row;
        int sent;
        int phase_len;
        int push_bias;
        int focus;
        errors       = 0;
        results_seen = 0;
        burst_left   = $urandom_range(1, 12);
        clear_stacks();
        directed_ops = '{
            '{MODE_POP,  2'd0, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
            '{MODE_POP,  2'd1, 32'hFFFF_FFFF, 1'b1, ST_EMPTY, 32'h0000_0000},
            '{MODE_POP,  2'd2, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
            '{MODE_POP,  2'd3, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
            '{MODE_PUSH, 2'd0, 32'h8000_0000, 1'b1, ST_OK,    32'h0000_0000},
            '{MODE_PUSH, 2'd3, 32'h7FFF_FFFF, 1'b1, ST_OK,    32'h0000_0000},
            '{MODE_PUSH, 2'd1, 32'h0000_0000, 1'b1, ST_OK,    32'h0000_0000},
            '{MODE_PUSH, 2'd2, 32'hFFFF_FFFF, 1'b1, ST_OK,    32'h0000_0000},
            '{MODE_PUSH, 2'd0, 32'h1234_5678, 1'b0, ST_OK,    32'h0000_0000},
            '{MODE_POP,  2'd3, 32'h0000_0000, 1'b1, ST_OK,    32'h7FFF_FFFF},
            '{MODE_POP,  2'd3, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
            '{MODE_POP,  2'd0, 32'hDEAD_BEEF, 1'b0, ST_OK,    32'h0000_0000},
            '{MODE_POP,  2'd0, 32'h0000_0000, 1'b1, ST_OK,    32'h8000_0000},
            '{MODE_POP,  2'd1, 32'h0000_0000, 1'b1, ST_OK,    32'h0000_0000},
            '{MODE_POP,  2'd2, 32'h0000_0000, 1'b1, ST_OK,    32'hFFFF_FFFF},
            '{MODE_POP,  2'd2, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000}
        };
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_mode     <= MODE_PUSH;
        i_stack_id <= '0;
        i_data_in  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_ops[k]) begin
            send_op(directed_ops[k]);
        end

        // The first phase leans on pushes so that the store fills and reports full.
        sent      = 0;
        push_bias = 90;
        while (sent < RANDOM_OPS) begin
            phase_len = $urandom_range(20, 60);
            focus     = ($urandom_range(0, 1) == 1) ? $urandom_range(0, NUM_STACKS - 1) : -1;
            for (int k = 0; k < phase_len && sent < RANDOM_OPS; k++) begin
                row.mode  = ($urandom_range(0, 99) < push_bias) ? MODE_PUSH : MODE_POP;
                row.sid   = (focus >= 0 && $urandom_range(0, 3) != 0) ?
                            ID_W'(focus) : ID_W'($urandom_range(0, (1 << ID_W) - 1));
                row.data  = pick_data();
                row.typed = 1'b0;
                row.st    = ST_OK;
                row.dout  = '0;
                send_op(row);
                sent++;
            end
            case ($urandom_range(0, 3))
                0: push_bias = 85;
                1: push_bias = 15;
                2: push_bias = 50;
                default: push_bias = 65;
            endcase
        end

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
